### hdl/ibfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibfg_pkg: shared types and constants for the boost frequency governor
// Command codes, configuration register indexes, field widths and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package ibfg_pkg;

  // Field widths
  localparam int FREQ_W    = 22;
  localparam int MS_W      = 16;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 3;

  // Command codes carried in the input word
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_USER_INPUT = 3'd1,
    CMD_INPUT_KICK = 3'd2,
    CMD_MAX_KICK   = 3'd3,
    CMD_SCREEN_ON  = 3'd4,
    CMD_SCREEN_OFF = 3'd5,
    CMD_QUERY      = 3'd6
  } cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_FREQ_LITTLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_FREQ_BIG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FLOOR_LITTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FLOOR_BIG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BOOST_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_BOOST_MS     = 3'd5;

  // Reset values of the boost length registers
  localparam logic [MS_W-1:0] INPUT_BOOST_MS_RST = 16'd64;
  localparam logic [MS_W-1:0] WAKE_BOOST_MS_RST  = 16'd1000;

endpackage
`default_nettype wire

### hdl/input_boost_frequency_governor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// input_boost_frequency_governor_top: screen and boost timer tracker
// Takes one command word per cycle when not stalled (tick, user input, kicks,
// screen on/off, policy query) and returns one result word per command: the
// frequency floor for a query plus the screen and boost flags after the command.
//
// Usage:
//  - Input channel in_*: valid/stall. One word is taken on any cycle with
//    in_valid high and in_stall low.
//  - Result channel out_*: valid/stall. Exactly one result word per command,
//    in order, appearing the cycle after the command is taken.
//  - Throughput is one word per cycle; the single result register is the
//    only storage between the channels, so in_stall follows out_stall only
//    while that register holds a word.
//  - Configuration cfg_*: valid/ready, always ready. Write only while idle.
//  - Reset (rst_n low, synchronous): screen awake, both boosts off, timers
//    zero, boost lengths 64 and 1000 ticks, frequency registers zero, no
//    result pending.
//  - A stalled result holds its word; new commands wait until it is taken.
// ----------------------------------------------------------------------------
module input_boost_frequency_governor_top
  import ibfg_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Command channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [MS_W-1:0]      in_duration_ticks,
  input  wire logic                 in_cpu_is_little,
  input  wire logic [FREQ_W-1:0]    in_policy_max_khz,
  input  wire logic [FREQ_W-1:0]    in_hw_min_khz,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FREQ_W-1:0]         out_policy_min_khz,
  output logic                      out_screen_on,
  output logic                      out_input_boosted,
  output logic                      out_max_boosted,
  // Configuration write port
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FREQ_W-1:0]    cfg_wdata
);

  localparam int FitW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

  // Saturate a loaded length to the timer width
  function automatic logic [TIMER_BITS-1:0] fit_timer(input logic [MS_W-1:0] v);
    logic [FitW-1:0] wide;
    logic [FitW-1:0] lim;
    wide = FitW'(v);
    lim  = FitW'({TIMER_BITS{1'b1}});
    if (wide > lim) begin
      fit_timer = '1;
    end else begin
      fit_timer = wide[TIMER_BITS-1:0];
    end
  endfunction

  // Configuration registers
  logic [FREQ_W-1:0]     boost_little_r, boost_big_r;
  logic [FREQ_W-1:0]     idle_little_r, idle_big_r;
  logic [MS_W-1:0]       input_ms_r, wake_ms_r;

  // Governor state
  logic                  awake_r, awake_nxt;
  logic                  in_act_r, in_act_nxt;
  logic                  max_act_r, max_act_nxt;
  logic [TIMER_BITS-1:0] in_rem_r, in_rem_nxt;
  logic [TIMER_BITS-1:0] max_rem_r, max_rem_nxt;

  // Result register
  logic                  out_valid_r;
  logic [FREQ_W-1:0]     floor_r, floor_nxt;
  logic                  scr_r, inb_r, maxb_r;

  logic                  in_acc;
  logic [MS_W-1:0]       max_len;
  logic [TIMER_BITS-1:0] max_load;
  logic [TIMER_BITS-1:0] in_load;
  logic [FREQ_W-1:0]     boost_sel, idle_sel;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  assign out_valid          = out_valid_r;
  assign out_policy_min_khz = floor_r;
  assign out_screen_on      = scr_r;
  assign out_input_boosted  = inb_r;
  assign out_max_boosted    = maxb_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_little_r <= '0;
      boost_big_r    <= '0;
      idle_little_r  <= '0;
      idle_big_r     <= '0;
      input_ms_r     <= INPUT_BOOST_MS_RST;
      wake_ms_r      <= WAKE_BOOST_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOOST_FREQ_LITTLE: boost_little_r <= cfg_wdata;
        CFG_BOOST_FREQ_BIG:    boost_big_r    <= cfg_wdata;
        CFG_IDLE_FLOOR_LITTLE: idle_little_r  <= cfg_wdata;
        CFG_IDLE_FLOOR_BIG:    idle_big_r     <= cfg_wdata;
        CFG_INPUT_BOOST_MS:    input_ms_r     <= cfg_wdata[MS_W-1:0];
        CFG_WAKE_BOOST_MS:     wake_ms_r      <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Load values for the two timers
  assign max_len   = (cmd_t'(in_cmd) == CMD_SCREEN_ON) ? wake_ms_r : in_duration_ticks;
  assign max_load  = fit_timer(max_len);
  assign in_load   = fit_timer(input_ms_r);
  assign boost_sel = in_cpu_is_little ? boost_little_r : boost_big_r;
  assign idle_sel  = in_cpu_is_little ? idle_little_r : idle_big_r;

  // Next state and floor for the word being taken
  always_comb begin
    awake_nxt   = awake_r;
    in_act_nxt  = in_act_r;
    max_act_nxt = max_act_r;
    in_rem_nxt  = in_rem_r;
    max_rem_nxt = max_rem_r;
    floor_nxt   = '0;
    case (cmd_t'(in_cmd))
      CMD_TICK: begin
        if (in_act_r) begin
          if (in_rem_r <= TIMER_BITS'(1)) begin
            in_act_nxt = 1'b0;
            in_rem_nxt = '0;
          end else begin
            in_rem_nxt = in_rem_r - TIMER_BITS'(1);
          end
        end
        if (max_act_r) begin
          if (max_rem_r <= TIMER_BITS'(1)) begin
            max_act_nxt = 1'b0;
            max_rem_nxt = '0;
          end else begin
            max_rem_nxt = max_rem_r - TIMER_BITS'(1);
          end
        end
      end
      CMD_USER_INPUT: begin
        if (awake_r) begin
          in_act_nxt = 1'b1;
          in_rem_nxt = in_load;
        end
      end
      CMD_INPUT_KICK: begin
        in_act_nxt = 1'b1;
        in_rem_nxt = in_load;
      end
      CMD_MAX_KICK, CMD_SCREEN_ON: begin
        if (cmd_t'(in_cmd) == CMD_SCREEN_ON) begin
          awake_nxt = 1'b1;
        end
        // A longer running max boost is kept
        if (!(max_act_r && (max_rem_r > max_load))) begin
          max_act_nxt = 1'b1;
          max_rem_nxt = max_load;
        end
      end
      CMD_SCREEN_OFF: begin
        awake_nxt   = 1'b0;
        in_act_nxt  = 1'b0;
        max_act_nxt = 1'b0;
        in_rem_nxt  = '0;
        max_rem_nxt = '0;
      end
      CMD_QUERY: begin
        if (max_act_r) begin
          floor_nxt = in_policy_max_khz;
        end else if (in_act_r) begin
          floor_nxt = (in_policy_max_khz < boost_sel) ? in_policy_max_khz : boost_sel;
        end else begin
          floor_nxt = (in_hw_min_khz > idle_sel) ? in_hw_min_khz : idle_sel;
        end
      end
      default: ;
    endcase
  end

  // State update on each taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awake_r   <= 1'b1;
      in_act_r  <= 1'b0;
      max_act_r <= 1'b0;
      in_rem_r  <= '0;
      max_rem_r <= '0;
    end else if (in_acc) begin
      awake_r   <= awake_nxt;
      in_act_r  <= in_act_nxt;
      max_act_r <= max_act_nxt;
      in_rem_r  <= in_rem_nxt;
      max_rem_r <= max_rem_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      floor_r <= floor_nxt;
      scr_r   <= awake_nxt;
      inb_r   <= in_act_nxt;
      maxb_r  <= max_act_nxt;
    end
  end

  // Assertions
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result word pending");

  a_in_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_act_r |-> (in_rem_r == '0))
    else $error("input boost timer non-zero while inactive");

  a_max_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !max_act_r |-> (max_rem_r == '0))
    else $error("max boost timer non-zero while inactive");

  a_screen_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_cmd) == CMD_SCREEN_OFF)) |=>
      (out_valid_r && !inb_r && !maxb_r && !scr_r))
    else $error("screen off left a boost running");

  a_non_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_cmd) != CMD_QUERY)) |=> (floor_r == '0))
    else $error("non-query word reported a floor");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the input boost frequency governor
// Drives command words with random gaps against a randomly stalling result
// side, predicts the frequency floor and the screen and boost flags for every
// accepted word, and compares each result word with the oldest prediction.
// The run goes through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import ibfg_pkg::*;

  localparam int TB_TIMER_BITS = 16;
  localparam int NUM_REGS      = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 160;

  // Command code outside the defined set; the block must leave state alone
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam logic [FREQ_W-1:0] KHZ_MAX = {FREQ_W{1'b1}};
  localparam logic [MS_W-1:0]   MS_MAX  = {MS_W{1'b1}};

  typedef struct packed {
    logic [FREQ_W-1:0] floor_khz;
    logic              screen_on;
    logic              input_boosted;
    logic              max_boosted;
  } gov_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: governor state copy plus the queue of results still due
  // --------------------------------------------------------------------------
  class floor_scoreboard;
    gov_result_t due_results[$];
    int unsigned mismatches;

    logic [FREQ_W-1:0] boost_little, boost_big, idle_little, idle_big;
    logic [MS_W-1:0]   input_len, wake_len;

    bit                       awake, input_on, max_on;
    logic [TB_TIMER_BITS-1:0] input_left, max_left;

    function new();
      mismatches   = 0;
      boost_little = '0;
      boost_big    = '0;
      idle_little  = '0;
      idle_big     = '0;
      input_len    = INPUT_BOOST_MS_RST;
      wake_len     = WAKE_BOOST_MS_RST;
      awake        = 1'b1;
      input_on     = 1'b0;
      max_on       = 1'b0;
      input_left   = '0;
      max_left     = '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      case (idx)
        CFG_BOOST_FREQ_LITTLE: boost_little = data;
        CFG_BOOST_FREQ_BIG:    boost_big    = data;
        CFG_IDLE_FLOOR_LITTLE: idle_little  = data;
        CFG_IDLE_FLOOR_BIG:    idle_big     = data;
        CFG_INPUT_BOOST_MS:    input_len    = data[MS_W-1:0];
        CFG_WAKE_BOOST_MS:     wake_len     = data[MS_W-1:0];
        default: ;
      endcase
    endfunction

    // Loaded lengths saturate when the timer is narrower than the field
    function logic [TB_TIMER_BITS-1:0] clamp_len(logic [MS_W-1:0] len);
      longint unsigned top;
      top = (64'd1 << TB_TIMER_BITS) - 1;
      return (len > top) ? top[TB_TIMER_BITS-1:0] : len;
    endfunction

    function void count_down(inout bit active, inout logic [TB_TIMER_BITS-1:0] left);
      if (active) begin
        if (left <= 1) begin
          active = 1'b0;
          left   = '0;
        end else begin
          left = left - 1'b1;
        end
      end
    endfunction

    // Max boost is only replaced when the new length is not shorter
    function void start_max(logic [MS_W-1:0] len);
      logic [TB_TIMER_BITS-1:0] t;
      t = clamp_len(len);
      if (!(max_on && max_left > t)) begin
        max_on   = 1'b1;
        max_left = t;
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [MS_W-1:0] dur, logic little,
                               logic [FREQ_W-1:0] pmax, logic [FREQ_W-1:0] hw);
      gov_result_t       res;
      logic [FREQ_W-1:0] cap;
      res.floor_khz = '0;
      case (cmd)
        CMD_TICK: begin
          count_down(input_on, input_left);
          count_down(max_on, max_left);
        end
        CMD_USER_INPUT: begin
          if (awake) begin
            input_on   = 1'b1;
            input_left = clamp_len(input_len);
          end
        end
        CMD_INPUT_KICK: begin
          input_on   = 1'b1;
          input_left = clamp_len(input_len);
        end
        CMD_MAX_KICK: start_max(dur);
        CMD_SCREEN_ON: begin
          awake = 1'b1;
          start_max(wake_len);
        end
        CMD_SCREEN_OFF: begin
          awake      = 1'b0;
          input_on   = 1'b0;
          max_on     = 1'b0;
          input_left = '0;
          max_left   = '0;
        end
        CMD_QUERY: begin
          if (max_on) begin
            res.floor_khz = pmax;
          end else if (input_on) begin
            cap = little ? boost_little : boost_big;
            res.floor_khz = (pmax < cap) ? pmax : cap;
          end else begin
            cap = little ? idle_little : idle_big;
            res.floor_khz = (hw > cap) ? hw : cap;
          end
        end
        default: ;
      endcase
      res.screen_on     = awake;
      res.input_boosted = input_on;
      res.max_boosted   = max_on;
      due_results.push_back(res);
    endfunction

    function void check_result(gov_result_t got);
      gov_result_t exp_res;
      if (due_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result word with nothing due: floor=%0d scr=%0b in=%0b max=%0b",
                   $time, got.floor_khz, got.screen_on, got.input_boosted, got.max_boosted);
        mismatches++;
      end else begin
        exp_res = due_results.pop_front();
        if (got.floor_khz !== exp_res.floor_khz || got.screen_on !== exp_res.screen_on ||
            got.input_boosted !== exp_res.input_boosted ||
            got.max_boosted !== exp_res.max_boosted) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: mismatch floor/scr/in/max exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                     $time, exp_res.floor_khz, exp_res.screen_on, exp_res.input_boosted,
                     exp_res.max_boosted, got.floor_khz, got.screen_on, got.input_boosted,
                     got.max_boosted);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd            = CMD_TICK;
  logic [MS_W-1:0]      in_duration_ticks = '0;
  logic                 in_cpu_is_little  = 1'b0;
  logic [FREQ_W-1:0]    in_policy_max_khz = '0;
  logic [FREQ_W-1:0]    in_hw_min_khz     = '0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [FREQ_W-1:0]    out_policy_min_khz;
  logic                 out_screen_on;
  logic                 out_input_boosted;
  logic                 out_max_boosted;
  logic                 cfg_valid         = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [FREQ_W-1:0]    cfg_wdata         = '0;

  bit          steady_run = 1'b0;
  int unsigned quiet_cycles = 0;

  floor_scoreboard sb = new();

  input_boost_frequency_governor_top #(
    .TIMER_BITS(TB_TIMER_BITS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_duration_ticks  (in_duration_ticks),
    .in_cpu_is_little   (in_cpu_is_little),
    .in_policy_max_khz  (in_policy_max_khz),
    .in_hw_min_khz      (in_hw_min_khz),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_policy_min_khz (out_policy_min_khz),
    .out_screen_on      (out_screen_on),
    .out_input_boosted  (out_input_boosted),
    .out_max_boosted    (out_max_boosted),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= !steady_run && ($urandom_range(0, 99) < 12);
  end

  // Handshake monitor: predict on accepted words, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result({out_policy_min_khz, out_screen_on, out_input_boosted,
                         out_max_boosted});
      if (in_valid && !in_stall)
        sb.note_command(in_cmd, in_duration_ticks, in_cpu_is_little, in_policy_max_khz,
                        in_hw_min_khz);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_wdata);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL input_boost_frequency_governor_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Present one word and hold it until taken; valid stays high on return
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [MS_W-1:0] dur,
                           input logic little, input logic [FREQ_W-1:0] pmax,
                           input logic [FREQ_W-1:0] hw);
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_duration_ticks <= dur;
    in_cpu_is_little  <= little;
    in_policy_max_khz <= pmax;
    in_hw_min_khz     <= hw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_pause();
    if (!steady_run && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every due result, plus the pipeline latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_settings(input logic [FREQ_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] pick_khz();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KHZ_MAX;
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    logic [MS_W-1:0]  dur;
    int unsigned      r;
    r = $urandom_range(0, 99);
    if (r < 35)      cmd = CMD_TICK;
    else if (r < 47) cmd = CMD_USER_INPUT;
    else if (r < 55) cmd = CMD_INPUT_KICK;
    else if (r < 65) cmd = CMD_MAX_KICK;
    else if (r < 70) cmd = CMD_SCREEN_ON;
    else if (r < 75) cmd = CMD_SCREEN_OFF;
    else if (r < 98) cmd = CMD_QUERY;
    else             cmd = CMD_UNUSED;
    dur = MS_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 40) : $urandom);
    send_item(cmd, dur, 1'($urandom_range(0, 1)), pick_khz(), pick_khz());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [FREQ_W-1:0] regs [NUM_REGS];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, screen transitions, ignored user input
    send_item(CMD_QUERY, '0, 1'b1, KHZ_MAX, KHZ_MAX);
    send_item(CMD_TICK, MS_MAX, 1'b0, '0, '0);
    send_item(CMD_USER_INPUT, '0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b0, '0, KHZ_MAX);
    send_item(CMD_SCREEN_ON, '0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b1, KHZ_MAX, '0);
    send_item(CMD_SCREEN_OFF, '0, 1'b0, '0, '0);
    send_item(CMD_USER_INPUT, '0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b0, KHZ_MAX, '0);
    wait_idle();

    regs[CFG_BOOST_FREQ_LITTLE] = 22'd1200000;
    regs[CFG_BOOST_FREQ_BIG]    = 22'd2000000;
    regs[CFG_IDLE_FLOOR_LITTLE] = 22'd300000;
    regs[CFG_IDLE_FLOOR_BIG]    = 22'd500000;
    regs[CFG_INPUT_BOOST_MS]    = 22'd2;
    regs[CFG_WAKE_BOOST_MS]     = 22'd3;
    load_settings(regs);

    // Directed: boost caps, expiry, max kick skip and reload, zero length
    send_item(CMD_INPUT_KICK, '0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b1, KHZ_MAX, '0);
    send_item(CMD_QUERY, '0, 1'b0, 22'd1000000, '0);
    send_item(CMD_TICK, '0, 1'b0, '0, '0);
    send_item(CMD_TICK, '0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b1, KHZ_MAX, 22'd100000);
    send_item(CMD_SCREEN_ON, '0, 1'b0, '0, '0);
    send_item(CMD_MAX_KICK, 16'd1, 1'b0, '0, '0);
    send_item(CMD_MAX_KICK, 16'd3, 1'b0, '0, '0);
    repeat (3) send_item(CMD_TICK, '0, 1'b0, '0, '0);
    send_item(CMD_MAX_KICK, 16'd0, 1'b0, '0, '0);
    send_item(CMD_QUERY, '0, 1'b0, 22'd777, KHZ_MAX);
    send_item(CMD_TICK, '0, 1'b0, '0, '0);
    send_item(CMD_UNUSED, MS_MAX, 1'b1, KHZ_MAX, KHZ_MAX);
    send_item(CMD_MAX_KICK, MS_MAX, 1'b1, KHZ_MAX, KHZ_MAX);
    send_item(CMD_SCREEN_OFF, '0, 1'b0, '0, '0);
    wait_idle();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
        2: for (int i = 0; i < NUM_REGS; i++) regs[i] = KHZ_MAX;
        default: begin
          regs[CFG_BOOST_FREQ_LITTLE] = FREQ_W'($urandom);
          regs[CFG_BOOST_FREQ_BIG]    = FREQ_W'($urandom);
          regs[CFG_IDLE_FLOOR_LITTLE] = FREQ_W'($urandom);
          regs[CFG_IDLE_FLOOR_BIG]    = FREQ_W'($urandom);
          // upper data bits are don't-care for the length registers
          regs[CFG_INPUT_BOOST_MS]    = FREQ_W'({$urandom_range(0, 63), 16'd0} |
                                                $urandom_range(0, 12));
          regs[CFG_WAKE_BOOST_MS]     = FREQ_W'({$urandom_range(0, 63), 16'd0} |
                                                ((p == 5) ? $urandom : $urandom_range(0, 30)));
        end
      endcase
      load_settings(regs);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long stretch with neither side idling
        if (p == 3) steady_run = (n < 100);
        send_random_item();
        if (p == 4 && n == 80) begin
          wait_idle();
        end else begin
          maybe_pause();
        end
      end
      steady_run = 1'b0;
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS input_boost_frequency_governor_top");
    else
      $display("FAIL input_boost_frequency_governor_top");
    $finish;
  end

endmodule

### input_boost_frequency_governor_top.f
hdl/ibfg_pkg.sv
hdl/input_boost_frequency_governor_top.sv
verif/tb_top.sv
